// ===== design/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg
// Shared widths, codes and payload types of the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

   // Coordinate and register widths
   localparam int COORD_BITS = 10;
   localparam int GRID_BITS  = COORD_BITS + 1;
   // Decision term stays inside (-2*major, 2*minor], so this leaves headroom
   localparam int DEC_BITS   = COORD_BITS + 3;

   // Register reset values
   localparam logic [GRID_BITS-1:0] GRID_WIDTH_RESET  = GRID_BITS'(300);
   localparam logic [GRID_BITS-1:0] GRID_HEIGHT_RESET = GRID_BITS'(150);

   // Configuration register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // Command kinds
   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_NO_LINE = 2'd2;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
      logic [1:0]            status;
   } rsp_payload_type;

   // Line state that a line command sets up
   typedef struct packed {
      logic                       outside;
      logic                       x_is_major;
      logic                       minor_goes_down;
      logic                       active;
      logic [COORD_BITS-1:0]      cur_major;
      logic [COORD_BITS-1:0]      cur_minor;
      logic [COORD_BITS-1:0]      abs_major;
      logic [COORD_BITS-1:0]      abs_minor;
      logic signed [DEC_BITS-1:0] decision;
   } line_setup_type;

endpackage

// ===== design/brl_line_setup.sv =====
// ----------------------------------------------------------------------------
// brl_line_setup
// Grid check, major axis choice, endpoint ordering and initial decision term
// for a line command.
// ----------------------------------------------------------------------------
module brl_line_setup import brl_pkg::*; (
   input  req_payload_type      cmd,
   input  logic [GRID_BITS-1:0] grid_width,
   input  logic [GRID_BITS-1:0] grid_height,
   output line_setup_type       setup
);

   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic                  x_major;
   logic [COORD_BITS-1:0] ma0;
   logic [COORD_BITS-1:0] ma1;
   logic [COORD_BITS-1:0] mi0;
   logic [COORD_BITS-1:0] mi1;
   logic                  swap;
   logic [COORD_BITS-1:0] first_minor;
   logic [COORD_BITS-1:0] far_minor;
   logic [COORD_BITS-1:0] amaj;
   logic [COORD_BITS-1:0] amin;

   // Check both endpoints against the grid limits
   assign setup.outside = ({1'b0, cmd.start_x} >= grid_width)  ||
                          ({1'b0, cmd.end_x}   >= grid_width)  ||
                          ({1'b0, cmd.start_y} >= grid_height) ||
                          ({1'b0, cmd.end_y}   >= grid_height);

   // Take absolute deltas and pick the major axis (ties go to x)
   assign adx = (cmd.start_x > cmd.end_x) ? cmd.start_x - cmd.end_x
                                          : cmd.end_x - cmd.start_x;
   assign ady = (cmd.start_y > cmd.end_y) ? cmd.start_y - cmd.end_y
                                          : cmd.end_y - cmd.start_y;
   assign x_major = (ady <= adx);

   always_comb begin
      if (x_major) begin
         ma0  = cmd.start_x;
         ma1  = cmd.end_x;
         mi0  = cmd.start_y;
         mi1  = cmd.end_y;
         amaj = adx;
         amin = ady;
      end else begin
         ma0  = cmd.start_y;
         ma1  = cmd.end_y;
         mi0  = cmd.start_x;
         mi1  = cmd.end_x;
         amaj = ady;
         amin = adx;
      end
   end

   // Order endpoints so the walk runs up the major axis
   assign swap        = (ma0 > ma1);
   assign first_minor = swap ? mi1 : mi0;
   assign far_minor   = swap ? mi0 : mi1;

   assign setup.x_is_major      = x_major;
   assign setup.minor_goes_down = (far_minor < first_minor);
   assign setup.cur_major       = swap ? ma1 : ma0;
   assign setup.cur_minor       = first_minor;
   assign setup.abs_major       = amaj;
   assign setup.abs_minor       = amin;
   assign setup.active          = (amaj != '0);

   // Initial term 2*minor - major
   assign setup.decision = $signed({2'b00, amin, 1'b0}) - $signed({3'b000, amaj});

endmodule

// ===== design/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer Bresenham line walker over a configurable grid: one result per
// command, line commands set up a walk and step commands advance it.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_payload_type (command)
//   rsp      out        rsp_valid/rsp_ready  rsp_payload_type (pixel, status)
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// Each command is worked in the cycle it is accepted and its result is
// registered into the output stage; one command per cycle is sustained
// while rsp does not stall, set by the update of the line state (decision add and compare).
// A two-entry output stage (output register plus skid) holds results while
// rsp stalls; req_ready drops only when both entries are full.
// Synchronous active-high reset clears the valid bits and the active line
// and loads the grid registers with 300 by 150.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer import brl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_write_en,
   input  logic                 csr_index,
   input  logic [GRID_BITS-1:0] csr_wdata
);

   // Configuration
   logic [GRID_BITS-1:0] grid_width_ff;
   logic [GRID_BITS-1:0] grid_height_ff;

   // Line state
   logic                       line_active_ff,     line_active_in;
   logic                       x_is_major_ff,      x_is_major_in;
   logic                       minor_goes_down_ff, minor_goes_down_in;
   logic [COORD_BITS-1:0]      cur_major_ff,       cur_major_in;
   logic [COORD_BITS-1:0]      cur_minor_ff,       cur_minor_in;
   logic [COORD_BITS-1:0]      abs_major_ff,       abs_major_in;
   logic [COORD_BITS-1:0]      abs_minor_ff,       abs_minor_in;
   logic [COORD_BITS-1:0]      steps_left_ff,      steps_left_in;
   logic signed [DEC_BITS-1:0] decision_ff,        decision_in;

   // Output stage
   logic            out_valid_ff,  out_valid_in;
   rsp_payload_type out_data_ff,   out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff,  skid_data_in;

   line_setup_type             setup;
   rsp_payload_type            result;
   logic                       req_transfer;
   logic                       rsp_transfer;
   logic                       dec_positive;
   logic signed [DEC_BITS-1:0] two_minor;
   logic signed [DEC_BITS-1:0] two_major;
   logic [COORD_BITS-1:0]      step_major;
   logic [COORD_BITS-1:0]      step_minor;
   logic [COORD_BITS-1:0]      step_left;

   assign req_ready    = !skid_valid_ff;
   assign req_transfer = req_valid && req_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp_payload  = out_data_ff;
   assign rsp_transfer = out_valid_ff && rsp_ready;

   // Write the grid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            default:         grid_width_ff  <= grid_width_ff;
         endcase
      end
   end

   brl_line_setup u_setup (
      .cmd         (req_payload),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .setup       (setup)
   );

   // Advance the walk by one pixel
   assign two_minor    = $signed({2'b00, abs_minor_ff, 1'b0});
   assign two_major    = $signed({2'b00, abs_major_ff, 1'b0});
   assign dec_positive = !decision_ff[DEC_BITS-1] && (decision_ff != '0);
   assign step_major   = cur_major_ff + COORD_BITS'(1);
   assign step_left    = steps_left_ff - COORD_BITS'(1);

   always_comb begin
      if (!dec_positive) begin
         step_minor = cur_minor_ff;
      end else if (minor_goes_down_ff) begin
         step_minor = cur_minor_ff - COORD_BITS'(1);
      end else begin
         step_minor = cur_minor_ff + COORD_BITS'(1);
      end
   end

   // Pick next line state and the result of this command
   always_comb begin
      line_active_in     = line_active_ff;
      x_is_major_in      = x_is_major_ff;
      minor_goes_down_in = minor_goes_down_ff;
      cur_major_in       = cur_major_ff;
      cur_minor_in       = cur_minor_ff;
      abs_major_in       = abs_major_ff;
      abs_minor_in       = abs_minor_ff;
      steps_left_in      = steps_left_ff;
      decision_in        = decision_ff;
      result             = '0;

      if (req_payload.kind == KIND_LINE) begin
         if (setup.outside) begin
            line_active_in = 1'b0;
            result.status  = STATUS_OUTSIDE;
         end else begin
            line_active_in     = setup.active;
            x_is_major_in      = setup.x_is_major;
            minor_goes_down_in = setup.minor_goes_down;
            cur_major_in       = setup.cur_major;
            cur_minor_in       = setup.cur_minor;
            abs_major_in       = setup.abs_major;
            abs_minor_in       = setup.abs_minor;
            steps_left_in      = setup.abs_major;
            decision_in        = setup.decision;
            result.pixel_x     = setup.x_is_major ? setup.cur_major : setup.cur_minor;
            result.pixel_y     = setup.x_is_major ? setup.cur_minor : setup.cur_major;
            result.last_pixel  = !setup.active;
            result.status      = STATUS_OK;
         end
      end else if (!line_active_ff) begin
         result.status = STATUS_NO_LINE;
      end else begin
         cur_major_in      = step_major;
         cur_minor_in      = step_minor;
         steps_left_in     = step_left;
         line_active_in    = (step_left != '0);
         decision_in       = dec_positive ? decision_ff + two_minor - two_major
                                          : decision_ff + two_minor;
         result.pixel_x    = x_is_major_ff ? step_major : step_minor;
         result.pixel_y    = x_is_major_ff ? step_minor : step_major;
         result.last_pixel = (step_left == '0);
         result.status     = STATUS_OK;
      end
   end

   // Hold line state, update on an accepted command
   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
      end else if (req_transfer) begin
         line_active_ff <= line_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         x_is_major_ff      <= x_is_major_in;
         minor_goes_down_ff <= minor_goes_down_in;
         cur_major_ff       <= cur_major_in;
         cur_minor_ff       <= cur_minor_in;
         abs_major_ff       <= abs_major_in;
         abs_minor_ff       <= abs_minor_in;
         steps_left_ff      <= steps_left_in;
         decision_ff        <= decision_in;
      end
   end

   // Load the output register, park a result in the skid while rsp stalls
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         out_valid_in  = skid_valid_ff || req_transfer;
         out_data_in   = skid_valid_ff ? skid_data_ff : result;
         skid_valid_in = 1'b0;
      end else if (req_transfer) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (steps_left_ff != '0))
      else $error("active line with no steps left");

   a_outside_cancels: assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_payload.kind == KIND_LINE && setup.outside)
      |=> !line_active_ff)
      else $error("line still active after endpoint outside grid");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.last_pixel) |-> (out_data_ff.status == STATUS_OK))
      else $error("last pixel flagged on an error result");

endmodule

// ===== dv/bresenham_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_tb
// Self-checking bench for the Bresenham line walker. A queue of line and step
// commands feeds a valid/ready driver. A predictor works out every pixel and
// status on each command transfer. A monitor compares each
// result transfer with the oldest prediction. Grid sizes change between
// phases while the block is idle, and both sides throttle at random.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_tb;
   import brl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 200;
   localparam int PRINT_CAP    = 40;
   localparam int REQ_BITS     = $bits(req_payload_type);

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   req_payload_type      req_payload  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_write_en = 1'b0;
   logic                 csr_index    = CSR_GRID_WIDTH;
   logic [GRID_BITS-1:0] csr_wdata    = '0;

   bresenham_line_rasterizer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Commands waiting to be driven, and pixels waiting to come out
   req_payload_type pending_cmds[$];
   rsp_payload_type expected_pixels[$];

   int error_count  = 0;
   int cycle_count  = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int rsp_count    = 0;
   int hold_left    = 0;
   bit hold_armed   = 1'b0;
   bit hold_done    = 1'b0;

   // Predicted grid and walk state
   logic [GRID_BITS-1:0]       grid_w = GRID_WIDTH_RESET;
   logic [GRID_BITS-1:0]       grid_h = GRID_HEIGHT_RESET;
   logic [COORD_BITS-1:0]      walk_major    = '0;
   logic [COORD_BITS-1:0]      walk_minor    = '0;
   logic signed [DEC_BITS-1:0] walk_term     = '0;
   logic [COORD_BITS-1:0]      span_major    = '0;
   logic [COORD_BITS-1:0]      span_minor    = '0;
   logic [COORD_BITS-1:0]      steps_remaining = '0;
   logic                       x_major       = 1'b0;
   logic                       minor_down    = 1'b0;
   logic                       walking       = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Pixel of the current walk position
   function automatic rsp_payload_type walk_pixel();
      rsp_payload_type px;
      px.pixel_x    = x_major ? walk_major : walk_minor;
      px.pixel_y    = x_major ? walk_minor : walk_major;
      px.last_pixel = ~walking;
      px.status     = STATUS_OK;
      return px;
   endfunction

   // Advance the walk for one command and return the result it causes
   function automatic rsp_payload_type predict_pixel(req_payload_type cmd);
      rsp_payload_type       px;
      logic [COORD_BITS-1:0] adx, ady, ma0, ma1, mi0, mi1;
      px = '0;
      if (cmd.kind == KIND_LINE) begin
         if (cmd.start_x >= grid_w || cmd.end_x >= grid_w ||
             cmd.start_y >= grid_h || cmd.end_y >= grid_h) begin
            walking   = 1'b0;
            px.status = STATUS_OUTSIDE;
            return px;
         end
         adx = (cmd.start_x > cmd.end_x) ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
         ady = (cmd.start_y > cmd.end_y) ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
         x_major = (ady <= adx);
         if (x_major) begin
            ma0 = cmd.start_x; ma1 = cmd.end_x; mi0 = cmd.start_y; mi1 = cmd.end_y;
            span_major = adx;
            span_minor = ady;
         end else begin
            ma0 = cmd.start_y; ma1 = cmd.end_y; mi0 = cmd.start_x; mi1 = cmd.end_x;
            span_major = ady;
            span_minor = adx;
         end
         // Walk upward along the major axis
         if (ma0 > ma1) begin
            ma0 = ma1;
            {mi0, mi1} = {mi1, mi0};
         end
         minor_down      = (mi1 < mi0);
         walk_major      = ma0;
         walk_minor      = mi0;
         walk_term       = $signed({2'b00, span_minor, 1'b0}) - $signed({3'b000, span_major});
         steps_remaining = span_major;
         walking         = (steps_remaining != 0);
         return walk_pixel();
      end
      if (!walking) begin
         px.status = STATUS_NO_LINE;
         return px;
      end
      walk_major = walk_major + 1'b1;
      if (walk_term > 0) begin
         walk_minor = minor_down ? walk_minor - 1'b1 : walk_minor + 1'b1;
         walk_term  = walk_term + $signed({2'b00, span_minor, 1'b0})
                                - $signed({2'b00, span_major, 1'b0});
      end else begin
         walk_term = walk_term + $signed({2'b00, span_minor, 1'b0});
      end
      steps_remaining = steps_remaining - 1'b1;
      if (steps_remaining == 0)
         walking = 1'b0;
      return walk_pixel();
   endfunction

   task automatic report_fault(string msg);
      if (error_count < PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_fault($sformatf("pixel %0d %s got %0d want %0d", rsp_count, name, got, want));
   endtask

   // Driver: present the next queued command once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && req_ready)
            expected_pixels.push_back(predict_pixel(req_payload));
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
               req_payload <= pending_cmds.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer, throttle ready, hold off once
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_fault($sformatf("result %0d with nothing expected", rsp_count));
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_x", 16'(rsp_payload.pixel_x), 16'(want.pixel_x));
               check_field("pixel_y", 16'(rsp_payload.pixel_y), 16'(want.pixel_y));
               check_field("last_pixel", 16'(rsp_payload.last_pixel), 16'(want.last_pixel));
               check_field("status", 16'(rsp_payload.status), 16'(want.status));
            end
            rsp_count++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_payload_type line_cmd(int sx, int sy, int ex, int ey);
      req_payload_type cmd;
      cmd.kind    = KIND_LINE;
      cmd.start_x = COORD_BITS'(sx);
      cmd.start_y = COORD_BITS'(sy);
      cmd.end_x   = COORD_BITS'(ex);
      cmd.end_y   = COORD_BITS'(ey);
      return cmd;
   endfunction

   // Step command; its coordinates are don't-care, so fill them with noise
   function automatic req_payload_type step_cmd();
      req_payload_type cmd;
      cmd      = req_payload_type'(REQ_BITS'($urandom));
      cmd.kind = KIND_STEP;
      return cmd;
   endfunction

   // Coordinate near base, mostly close, kept inside [0, lim-1]
   function automatic int pick_near(int base, int lim);
      int r, span, v;
      r = $urandom_range(0, 99);
      if (r < 75)      span = $urandom_range(0, 12);
      else if (r < 98) span = $urandom_range(0, 80);
      else             span = $urandom_range(0, 1023);
      v = $urandom_range(0, 1) ? base + span : base - span;
      if (v < 0) v = 0;
      if (v > lim - 1) v = lim - 1;
      return v;
   endfunction

   // Queue mostly well-formed lines followed by their steps, plus noise
   task automatic gen_random_cmds(int count);
      int produced, lim_x, lim_y, sx, sy, ex, ey, dx, dy, major, steps, r, v;
      produced = 0;
      while (produced < count) begin
         lim_x = (grid_w > 1024) ? 1024 : int'(grid_w);
         lim_y = (grid_h > 1024) ? 1024 : int'(grid_h);
         r = $urandom_range(0, 99);
         if (r < 10 || lim_x == 0 || lim_y == 0) begin
            pending_cmds.push_back(req_payload_type'(REQ_BITS'({$urandom, $urandom})));
            produced++;
         end else begin
            sx = $urandom_range(0, lim_x - 1);
            sy = $urandom_range(0, lim_y - 1);
            ex = pick_near(sx, lim_x);
            ey = pick_near(sy, lim_y);
            // Push an endpoint past the grid now and then
            if (r < 15 && lim_x < 1024)      ex = $urandom_range(lim_x, 1023);
            else if (r < 20 && lim_y < 1024) sy = $urandom_range(lim_y, 1023);
            dx = (sx > ex) ? sx - ex : ex - sx;
            dy = (sy > ey) ? sy - ey : ey - sy;
            major = (dx > dy) ? dx : dy;
            v = $urandom_range(0, 99);
            if (v < 10)      steps = $urandom_range(0, major);
            else if (v < 18) steps = major + $urandom_range(1, 3);
            else             steps = major;
            pending_cmds.push_back(line_cmd(sx, sy, ex, ey));
            repeat (steps) pending_cmds.push_back(step_cmd());
            produced += 1 + steps;
         end
      end
   endtask

   // Hold until every command is driven and every result has come back
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid(int width, int height);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_GRID_WIDTH;
      csr_wdata    <= GRID_BITS'(width);
      grid_w        = GRID_BITS'(width);
      @(posedge clock);
      csr_index    <= CSR_GRID_HEIGHT;
      csr_wdata    <= GRID_BITS'(height);
      grid_h        = GRID_BITS'(height);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Sequence the phases
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 35;
      rcv_idle_pct = 49;

      // Directed commands on the reset grid of 300 by 150
      pending_cmds.push_back(step_cmd());                  // step with no line
      pending_cmds.push_back(line_cmd(0, 0, 0, 0));        // degenerate line
      pending_cmds.push_back(step_cmd());
      pending_cmds.push_back(line_cmd(299, 149, 299, 149)); // far grid corner
      pending_cmds.push_back(line_cmd(300, 0, 0, 0));      // x past the grid
      pending_cmds.push_back(line_cmd(0, 150, 0, 0));      // y past the grid
      pending_cmds.push_back(line_cmd(0, 0, 1023, 1023));  // far end past both
      pending_cmds.push_back(line_cmd(0, 0, 3, 3));        // equal magnitudes
      repeat (3) pending_cmds.push_back(step_cmd());
      pending_cmds.push_back(line_cmd(5, 1, 3, 7));        // steep, minor goes down
      repeat (2) pending_cmds.push_back(step_cmd());
      pending_cmds.push_back(line_cmd(6, 3, 2, 1));        // replaces the walk, swapped
      repeat (5) pending_cmds.push_back(step_cmd());       // one step past the end
      pending_cmds.push_back(line_cmd(0, 0, 5, 1));
      pending_cmds.push_back(step_cmd());
      pending_cmds.push_back(line_cmd(0, 0, 400, 0));      // outside cancels the walk
      pending_cmds.push_back(step_cmd());
      wait_quiet();

      write_grid(1024, 1024);
      gen_random_cmds(250);
      wait_quiet();
      write_grid(1, 1);
      gen_random_cmds(30);
      wait_quiet();
      write_grid(0, 1024);                                  // zero width grid
      gen_random_cmds(20);
      wait_quiet();

      snd_idle_pct = 49;
      rcv_idle_pct = 35;
      write_grid(2047, 7);
      gen_random_cmds(150);
      wait_quiet();
      write_grid($urandom_range(1, 1024), $urandom_range(1, 1024));
      gen_random_cmds(150);
      wait_quiet();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_grid(1024, 0);                                  // zero height grid
      gen_random_cmds(20);
      wait_quiet();
      write_grid($urandom_range(1, 1024), $urandom_range(1, 1024));
      gen_random_cmds(230);
      // Stall the result side while commands keep coming
      hold_armed = 1'b1;
      wait_quiet();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
